### rtl/packed_date_expiry_checker_macros.svh
// Assertion macros for the packed date expiry checker.
// Used by the port checker; depends on nothing else.
`ifndef PACKED_DATE_EXPIRY_CHECKER_MACROS_SVH
`define PACKED_DATE_EXPIRY_CHECKER_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define PDEC_ASSERT_SAME(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error("pdec: same-cycle check failed");

// Condition holds in the cycle after the trigger.
`define PDEC_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("pdec: next-cycle check failed");

`endif

### rtl/pdec_pkg.sv
// Shared types, codes and date helpers for the packed date expiry checker.
// No dependencies.
package pdec_pkg;

    localparam logic [11:0] YEAR_BASE = 12'd1900;

    // verdict codes
    localparam logic [1:0] VERDICT_GOOD    = 2'd0;
    localparam logic [1:0] VERDICT_OLD     = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TODAY_DAY   = 2'd0;
    localparam logic [1:0] REG_TODAY_MONTH = 2'd1;
    localparam logic [1:0] REG_TODAY_YEAR  = 2'd2;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // result of one month step
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [9:0]  year_off;
        logic [12:0] dur;
        logic        done;
    } step_t;

    // Year held as offset from 1900; every reachable year lies in 1900..2447,
    // so the century years are a short list.
    function automatic logic is_leap_off(input logic [9:0] off);
        logic by4;
        logic cent;
        logic by400;
        by4   = (off[1:0] == 2'b00);
        cent  = (off == 10'd0) || (off == 10'd100) || (off == 10'd200) ||
                (off == 10'd300) || (off == 10'd400) || (off == 10'd500);
        by400 = (off == 10'd100) || (off == 10'd500);
        return by400 || (by4 && !cent);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

    // a strictly before b
    function automatic logic date_before(input logic [11:0] ay, input logic [3:0] am,
                                         input logic [4:0] ad, input logic [11:0] by,
                                         input logic [3:0] bm, input logic [4:0] bd);
        logic r;
        if (ay != by) begin
            r = (ay < by);
        end else if (am != bm) begin
            r = (am < bm);
        end else begin
            r = (ad < bd);
        end
        return r;
    endfunction

endpackage

### rtl/packed_date_expiry_checker.sv
// Top level of the packed date expiry checker.
// Depends on pdec_pkg and pdec_month_step.
//
// Takes one packed record (day, month, year-1900, duration, parity) per request
// and returns one result: verdict plus end date. A record is captured, then
// validated, then the month step unit crosses one month boundary per step,
// and a final step ends inside the end month; an invalid record is answered
// after validation. A finished result waits while the output register is full.
// The input side is not ready while a record is in work; the result sits in
// an output register so the next record can be taken while it waits.
// Configuration writes are always accepted and take effect at once.
module packed_date_expiry_checker
    import pdec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // input records
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // packed_word[31:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // verdict[1:0], end_day[6:2], end_month[10:7],
                                   // end_year[22:11], zero pad[23]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP
    } state_t;

    state_t      state_reg;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [9:0]  yoff_reg;
    logic [12:0] dur_reg;
    logic        odd_reg;
    logic [4:0]  today_day_reg;
    logic [3:0]  today_month_reg;
    logic [11:0] today_year_reg;
    logic        m_valid_reg;
    logic [1:0]  verdict_reg;
    logic [4:0]  end_day_reg;
    logic [3:0]  end_month_reg;
    logic [11:0] end_year_reg;

    step_t       step;
    logic        out_free;
    logic        out_load;
    logic [11:0] start_year;
    logic [11:0] step_year;
    logic        bad;
    logic        too_old;

    pdec_month_step u_step (
        .day      (day_reg),
        .month    (month_reg),
        .year_off (yoff_reg),
        .dur      (dur_reg),
        .step     (step)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, end_year_reg, end_month_reg, end_day_reg, verdict_reg};

    assign out_free   = !m_valid_reg || m_tready;
    assign start_year = YEAR_BASE + {2'd0, yoff_reg};
    assign step_year  = YEAR_BASE + {2'd0, step.year_off};

    assign bad = odd_reg || (month_reg == 4'd0) || (month_reg > MONTH_DEC) ||
                 (day_reg == 5'd0) ||
                 (day_reg > month_len(month_reg, is_leap_off(yoff_reg))) ||
                 date_before(today_year_reg, today_month_reg, today_day_reg,
                             start_year, month_reg, day_reg);

    assign too_old = date_before(step_year, step.month, step.day,
                                 today_year_reg, today_month_reg, today_day_reg);

    // a result enters the output register this cycle
    assign out_load = out_free && (((state_reg == ST_CHECK) && bad) ||
                                   ((state_reg == ST_STEP) && step.done));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            today_day_reg   <= 5'd1;
            today_month_reg <= 4'd11;
            today_year_reg  <= 12'd2025;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TODAY_DAY:   today_day_reg   <= cfg_data[4:0];
                    REG_TODAY_MONTH: today_month_reg <= cfg_data[3:0];
                    REG_TODAY_YEAR:  today_year_reg  <= cfg_data;
                    default: ;
                endcase
            end

            m_valid_reg <= out_load || (m_valid_reg && !m_tready);

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        day_reg   <= s_tdata[4:0];
                        month_reg <= s_tdata[8:5];
                        yoff_reg  <= {1'b0, s_tdata[17:9]};
                        dur_reg   <= s_tdata[30:18];
                        odd_reg   <= ^s_tdata;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (bad) begin
                        // hold until the output register frees up
                        if (out_free) begin
                            verdict_reg   <= VERDICT_INVALID;
                            end_day_reg   <= 5'd0;
                            end_month_reg <= 4'd0;
                            end_year_reg  <= 12'd0;
                            state_reg     <= ST_IDLE;
                        end
                    end else begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (step.done) begin
                        if (out_free) begin
                            verdict_reg   <= too_old ? VERDICT_OLD : VERDICT_GOOD;
                            end_day_reg   <= step.day;
                            end_month_reg <= step.month;
                            end_year_reg  <= step_year;
                            state_reg     <= ST_IDLE;
                        end
                    end else begin
                        // advance to the first day of the next month
                        day_reg   <= step.day;
                        month_reg <= step.month;
                        yoff_reg  <= step.year_off;
                        dur_reg   <= step.dur;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/pdec_month_step.sv
// Month step unit: advances a date to the next month start or finishes inside it.
// Depends on pdec_pkg.
module pdec_month_step
    import pdec_pkg::*;
(
    input  logic [4:0]  day,
    input  logic [3:0]  month,
    input  logic [9:0]  year_off,
    input  logic [12:0] dur,
    output step_t       step
);

    logic [4:0] len;
    logic [4:0] left;

    assign len  = month_len(month, is_leap_off(year_off));
    assign left = len - day;

    always_comb begin
        step.done     = (dur <= {8'd0, left});
        step.day      = day;
        step.month    = month;
        step.year_off = year_off;
        step.dur      = dur;
        if (step.done) begin
            step.day = day + dur[4:0];
        end else begin
            step.dur = dur - ({8'd0, left} + 13'd1);
            step.day = 5'd1;
            if (month == MONTH_DEC) begin
                step.month    = 4'd1;
                step.year_off = year_off + 10'd1;
            end else begin
                step.month = month + 4'd1;
            end
        end
    end

endmodule

### rtl/pdec_checker.sv
// Port-level checker for the packed date expiry checker, bound to the top level.
// Depends on pdec_pkg and packed_date_expiry_checker_macros.svh.
`include "packed_date_expiry_checker_macros.svh"

module pdec_checker
    import pdec_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic out_stall;
    logic out_invalid;

    assign out_stall   = m_tvalid && !m_tready;
    assign out_invalid = m_tvalid && (m_tdata[1:0] == VERDICT_INVALID);

    // a stalled result holds
    `PDEC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata))

    // invalid results carry an all-zero date
    `PDEC_ASSERT_SAME(a_invalid_zero, aclk, aresetn, out_invalid, m_tdata[23:2] == 22'd0)

    // no verdict beyond the defined codes
    `PDEC_ASSERT_SAME(a_verdict_code, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)

    // one record at a time: busy right after a request is taken
    `PDEC_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind packed_date_expiry_checker pdec_checker u_pdec_checker (.*);

### tb/sv/packed_date_expiry_checker_tb.sv
// Self-checking bench for packed_date_expiry_checker: directed records, then random ones under
// several current-date settings; each result must match a listed value or the bench calculator.
// Depends on pdec_pkg and the packed_date_expiry_checker RTL.
`timescale 1ns / 100ps

module packed_date_expiry_checker_tb;
    import pdec_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } expiry_t;

    localparam expiry_t REJECTED = '{VERDICT_INVALID, 5'd0, 4'd0, 12'd0};

    typedef struct {
        logic [31:0] word;
        bit          typed;
        expiry_t     want;
    } directed_row_t;

    typedef struct {
        logic [4:0]  d;
        logic [3:0]  m;
        logic [11:0] y;
        int unsigned items;
        bit          gaps;
        bit          stray;
    } phase_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // bench copy of the current-date registers
    logic [4:0]  now_day = 5'd1;
    logic [3:0]  now_month = 4'd11;
    logic [11:0] now_year = 12'd2025;

    expiry_t     expected_results[$];
    expiry_t     want_now;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          gaps_on = 1'b1;

    packed_date_expiry_checker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic bit earlier(input int unsigned ay, input int unsigned am,
                                   input int unsigned ad, input int unsigned by,
                                   input int unsigned bm, input int unsigned bd);
        if (ay != by) return ay < by;
        if (am != bm) return am < bm;
        return ad < bd;
    endfunction

    // Validate the record, then walk the duration forward one month at a time.
    function automatic expiry_t expire_record(input logic [31:0] word);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned days;
        expiry_t     r;
        d    = word[4:0];
        m    = word[8:5];
        y    = word[17:9] + 1900;
        days = word[30:18];
        if ((^word) || m == 0 || m > 12 || d == 0 || d > days_in(m, y) ||
            earlier(now_year, now_month, now_day, y, m, d)) begin
            return REJECTED;
        end
        while (days > days_in(m, y) - d) begin
            days -= days_in(m, y) - d + 1;
            d = 1;
            m++;
            if (m == 13) begin
                m = 1;
                y++;
            end
        end
        d += days;
        r.verdict = earlier(y, m, d, now_year, now_month, now_day) ? VERDICT_OLD : VERDICT_GOOD;
        r.day     = 5'(d);
        r.month   = 4'(m);
        r.year    = 12'(y);
        return r;
    endfunction

    // parity bit on top makes the whole word even
    function automatic logic [31:0] pack_record(input logic [4:0] d, input logic [3:0] m,
                                                input logic [8:0] yoff, input logic [12:0] dur);
        logic [30:0] body;
        body = {dur, yoff, m, d};
        return {^body, body};
    endfunction

    // Mostly well-formed records near the current date, plus noise and broken ones.
    function automatic logic [31:0] random_record();
        int unsigned kind;
        int unsigned lo;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned dur;
        bit          flip;
        kind = $urandom_range(0, 99);
        flip = 1'b0;
        if (kind < 10) return $urandom();
        m = $urandom_range(1, 12);
        if (now_year >= 1900 && now_year <= 2411 && $urandom_range(0, 3) != 0) begin
            lo = (now_year > 1930) ? now_year - 30 : 1900;
            y  = $urandom_range(lo, now_year);
        end else begin
            y = $urandom_range(1900, 2411);
        end
        d   = $urandom_range(1, days_in(m, y));
        dur = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(0, 600);
        if (kind >= 80 && kind < 90 && now_year >= 1900 && now_year <= 2411) begin
            // start on the current date itself
            d   = now_day;
            m   = now_month;
            y   = now_year;
            dur = $urandom_range(0, 40);
        end else if (kind >= 90) begin
            case ($urandom_range(0, 3))
                0: flip = 1'b1;
                1: d = (days_in(m, y) < 31) ? $urandom_range(days_in(m, y) + 1, 31) : 0;
                2: d = 0;
                default: m = $urandom_range(0, 1) ? $urandom_range(13, 15) : 0;
            endcase
        end
        return pack_record(5'(d), 4'(m), 9'(y - 1900), 13'(dur)) ^ {flip, 31'd0};
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Offer one record with an optional random gap; record its expected result on accept.
    task automatic send_record(input logic [31:0] word, input bit typed, input expiry_t want);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(typed ? want : expire_record(word));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TODAY_DAY:   now_day = value[4:0];
            REG_TODAY_MONTH: now_month = value[3:0];
            REG_TODAY_YEAR:  now_year = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // result side: random backpressure bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (gaps_on && aresetn && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want_now = expected_results.pop_front();
                if (m_tdata[1:0] !== want_now.verdict)
                    report_mismatch($sformatf("verdict %0d, want %0d",
                                              m_tdata[1:0], want_now.verdict));
                if (m_tdata[6:2] !== want_now.day)
                    report_mismatch($sformatf("end_day %0d, want %0d",
                                              m_tdata[6:2], want_now.day));
                if (m_tdata[10:7] !== want_now.month)
                    report_mismatch($sformatf("end_month %0d, want %0d",
                                              m_tdata[10:7], want_now.month));
                if (m_tdata[22:11] !== want_now.year)
                    report_mismatch($sformatf("end_year %0d, want %0d",
                                              m_tdata[22:11], want_now.year));
                if (m_tdata[23] !== 1'b0)
                    report_mismatch("pad bit set");
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stalled with %0d results outstanding", expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        directed_row_t rows[$];
        phase_t        phases[$];
        // current date after reset is 2025-11-01; year offset 125 is 2025
        rows = '{
            '{32'h0000_0000, 1'b1, REJECTED},                              // month zero
            '{32'hFFFF_FFFF, 1'b1, REJECTED},                              // month 15
            '{pack_record(5'd15, 4'd6, 9'd100, 13'd10) ^ 32'h8000_0000, 1'b1, REJECTED},
            '{pack_record(5'd0, 4'd3, 9'd100, 13'd5), 1'b1, REJECTED},     // day zero
            '{pack_record(5'd31, 4'd4, 9'd100, 13'd0), 1'b1, REJECTED},    // April 31
            '{pack_record(5'd29, 4'd2, 9'd1, 13'd0), 1'b1, REJECTED},      // 1901 not leap
            '{pack_record(5'd29, 4'd2, 9'd0, 13'd0), 1'b1, REJECTED},      // 1900 century
            '{pack_record(5'd29, 4'd2, 9'd100, 13'd0), 1'b1,
              '{VERDICT_OLD, 5'd29, 4'd2, 12'd2000}},
            '{pack_record(5'd1, 4'd11, 9'd125, 13'd0), 1'b1,
              '{VERDICT_GOOD, 5'd1, 4'd11, 12'd2025}},                     // start is today
            '{pack_record(5'd2, 4'd11, 9'd125, 13'd0), 1'b1, REJECTED},    // after today
            '{pack_record(5'd31, 4'd10, 9'd125, 13'd0), 1'b1,
              '{VERDICT_OLD, 5'd31, 4'd10, 12'd2025}},
            '{pack_record(5'd31, 4'd10, 9'd125, 13'd1), 1'b1,
              '{VERDICT_GOOD, 5'd1, 4'd11, 12'd2025}},                     // ends today
            '{pack_record(5'd31, 4'd12, 9'd124, 13'd1), 1'b1,
              '{VERDICT_OLD, 5'd1, 4'd1, 12'd2025}},
            '{pack_record(5'd28, 4'd2, 9'd0, 13'd1), 1'b1,
              '{VERDICT_OLD, 5'd1, 4'd3, 12'd1900}},
            '{pack_record(5'd28, 4'd2, 9'd100, 13'd1), 1'b1,
              '{VERDICT_OLD, 5'd29, 4'd2, 12'd2000}},
            '{pack_record(5'd31, 4'd12, 9'd511, 13'd8191), 1'b1, REJECTED},
            '{pack_record(5'd1, 4'd1, 9'd0, 13'd8191), 1'b0, REJECTED},
            '{pack_record(5'd13, 4'd12, 9'd0, 13'd8191), 1'b0, REJECTED},
            '{pack_record(5'd31, 4'd1, 9'd125, 13'd30), 1'b0, REJECTED},
            '{pack_record(5'd1, 4'd11, 9'd125, 13'd8191), 1'b0, REJECTED},
            '{pack_record(5'd15, 4'd5, 9'd60, 13'd5000), 1'b0, REJECTED}
        };
        phases = '{
            '{5'd15, 4'd6,  12'd2000, 260, 1'b1, 1'b0},
            '{5'd31, 4'd12, 12'd2411, 260, 1'b1, 1'b0},
            '{5'd1,  4'd1,  12'd1900, 200, 1'b0, 1'b0},
            '{5'd31, 4'd15, 12'd4095, 260, 1'b1, 1'b0},
            '{5'd0,  4'd0,  12'd0,    150, 1'b1, 1'b0},
            '{5'd29, 4'd2,  12'd2024, 260, 1'b1, 1'b0},
            '{5'd0,  4'd0,  12'd0,    150, 1'b0, 1'b1}   // stray index, keep the date
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_record(rows[i].word, rows[i].typed, rows[i].want);

        foreach (phases[p]) begin
            drain();
            if (phases[p].stray) begin
                write_reg(REG_UNUSED, 12'hFFF);
            end else begin
                write_reg(REG_TODAY_DAY, {7'd0, phases[p].d});
                write_reg(REG_TODAY_MONTH, {8'd0, phases[p].m});
                write_reg(REG_TODAY_YEAR, phases[p].y);
            end
            cfg_valid <= 1'b0;
            gaps_on = phases[p].gaps;
            repeat (phases[p].items) send_record(random_record(), 1'b0, REJECTED);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
